/* rtl/core/tog_pkg.sv */
// Shared constants for the toroidal orbit generator: field widths, register
// indexes, reset values and the quarter-wave sine coefficients.
// No dependencies.
package tog_pkg;

   localparam int GRID_BITS_DEFAULT     = 12;
   localparam int POS_FRAC_BITS_DEFAULT = 8;
   localparam int TIME_BITS_DEFAULT     = 32;

   localparam int TIME_PORT_BITS = 32;
   localparam int Z_BITS         = 16;
   localparam int GRID_REG_BITS  = 13;
   localparam int PERIOD_BITS    = 16;
   localparam int AXIS_XY_BITS   = 64;
   localparam int AXIS_Z_BITS    = 48;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 64;

   localparam logic [CSR_INDEX_BITS-1:0] REG_GRID_WIDTH   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GRID_HEIGHT  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ORBIT_PERIOD = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_AXIS_X       = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_AXIS_Y       = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_AXIS_Z       = 3'd5;

   localparam logic [AXIS_XY_BITS-1:0] AXIS_XY_RESET = 64'h0000_0001_0000_0000;

   localparam int ACC_FRAC     = 18;
   localparam int FREQ_BITS    = 8;
   localparam int FIELD_BITS   = 16;
   localparam int TURN_BITS    = 16;
   localparam int SIN_ONE_BITS = 14;
   localparam int SINE_BITS    = 17;
   localparam int SINE_LAT     = 5;
   localparam int POLY_BITS    = 16;

   localparam logic [POLY_BITS-1:0] COEF_A = 16'd25736;
   localparam logic [POLY_BITS-1:0] COEF_B = 16'd10512;
   localparam logic [POLY_BITS-1:0] COEF_C = 16'd1160;

endpackage

/* rtl/core/tog_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
// Used by the toroidal orbit generator; no dependencies.
module tog_div #(
   parameter int DW = 16,
   parameter int NB = 16,
   parameter int TW = 1
) (
   input  logic          clock,
   input  logic          enable,
   input  logic [DW-1:0] start_rem,
   input  logic [NB-1:0] start_num,
   input  logic [DW-1:0] divisor,
   input  logic [TW-1:0] start_tag,
   output logic [NB-1:0] quotient,
   output logic [DW-1:0] remainder,
   output logic [TW-1:0] end_tag
);

   logic [DW-1:0] rem_ff  [NB];
   logic [NB-1:0] num_ff  [NB];
   logic [NB-1:0] quo_ff  [NB];
   logic [TW-1:0] tag_ff  [NB];
   logic [DW-1:0] rem_src [NB];
   logic [NB-1:0] num_src [NB];
   logic [NB-1:0] quo_src [NB];
   logic [DW-1:0] rem_in  [NB];
   logic [NB-1:0] num_in  [NB];
   logic [NB-1:0] quo_in  [NB];
   logic [DW:0]   trial   [NB];
   logic [NB-1:0] fits;

   always_comb begin
      rem_src[0] = start_rem;
      num_src[0] = start_num;
      quo_src[0] = '0;
      for (int k = 1; k < NB; k++) begin
         rem_src[k] = rem_ff[k-1];
         num_src[k] = num_ff[k-1];
         quo_src[k] = quo_ff[k-1];
      end
      for (int k = 0; k < NB; k++) begin
         trial[k]  = {rem_src[k], num_src[k][NB-1]};
         fits[k]   = trial[k] >= {1'b0, divisor};
         rem_in[k] = fits[k] ? DW'(trial[k] - {1'b0, divisor}) : DW'(trial[k]);
         num_in[k] = num_src[k] << 1;
         quo_in[k] = (quo_src[k] << 1) | NB'(fits[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         tag_ff[0] <= start_tag;
         for (int k = 0; k < NB; k++) begin
            rem_ff[k] <= rem_in[k];
            num_ff[k] <= num_in[k];
            quo_ff[k] <= quo_in[k];
         end
         for (int k = 1; k < NB; k++) begin
            tag_ff[k] <= tag_ff[k-1];
         end
      end
   end

   assign quotient  = quo_ff[NB-1];
   assign remainder = rem_ff[NB-1];
   assign end_tag   = tag_ff[NB-1];

endmodule

/* rtl/core/tog_sine.sv */
// Five-stage Q2.14 sine of a 16-bit turn fraction by an odd quarter-wave polynomial.
// Depends on tog_pkg.
module tog_sine (
   input  logic                                 clock,
   input  logic                                 enable,
   input  logic [tog_pkg::TURN_BITS-1:0]        turn,
   output logic signed [tog_pkg::SINE_BITS-1:0] sine
);
   import tog_pkg::*;

   localparam int PB = POLY_BITS;

   logic [1:0]    quad1_ff, quad2_ff, quad3_ff, quad4_ff;
   logic [PB-1:0] u1_ff, u2_ff, u3_ff, u4_ff;
   logic [PB-1:0] x2_ff, x3_ff;
   logic [PB-1:0] t1_ff, t_ff;
   logic signed [SINE_BITS-1:0] sine_ff;

   logic [PB-1:0]   u_in, x2_in, t1_in, t_in, mag;
   logic [2*PB-1:0] sq, cprod, tprod, sprod;
   logic signed [SINE_BITS-1:0] sine_in;

   always_comb begin
      u_in    = turn[SIN_ONE_BITS] ? PB'(PB'(1) << SIN_ONE_BITS) - PB'(turn[SIN_ONE_BITS-1:0])
                                   : PB'(turn[SIN_ONE_BITS-1:0]);
      sq      = u1_ff * u1_ff;
      x2_in   = PB'(sq >> SIN_ONE_BITS);
      cprod   = x2_ff * COEF_C;
      t1_in   = COEF_B - PB'(cprod >> SIN_ONE_BITS);
      tprod   = x3_ff * t1_ff;
      t_in    = COEF_A - PB'(tprod >> SIN_ONE_BITS);
      sprod   = u4_ff * t_ff;
      mag     = PB'(sprod >> SIN_ONE_BITS);
      sine_in = quad4_ff[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         quad1_ff <= turn[TURN_BITS-1 -: 2];
         u1_ff    <= u_in;
         quad2_ff <= quad1_ff;
         u2_ff    <= u1_ff;
         x2_ff    <= x2_in;
         quad3_ff <= quad2_ff;
         u3_ff    <= u2_ff;
         x3_ff    <= x2_ff;
         t1_ff    <= t1_in;
         quad4_ff <= quad3_ff;
         u4_ff    <= u3_ff;
         t_ff     <= t_in;
         sine_ff  <= sine_in;
      end
   end

   assign sine = sine_ff;

endmodule

/* rtl/core/toroidal_orbit_generator.sv */
// Toroidal orbit generator: one x, y, z orbit point per time-step request.
// Throughput one request per cycle unless a stalled response holds the pipeline;
// the rate is set by the bit-per-stage divider chains.
// Synchronous reset empties the pipeline and returns the configuration registers to defaults.
// Depends on tog_pkg, tog_div and tog_sine.
module toroidal_orbit_generator #(
   parameter int GRID_BITS     = tog_pkg::GRID_BITS_DEFAULT,
   parameter int POS_FRAC_BITS = tog_pkg::POS_FRAC_BITS_DEFAULT,
   parameter int TIME_BITS     = tog_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic [tog_pkg::TIME_PORT_BITS-1:0]        req_time_step,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic [GRID_BITS+POS_FRAC_BITS-1:0]        rsp_pos_x,
   output logic [GRID_BITS+POS_FRAC_BITS-1:0]        rsp_pos_y,
   output logic signed [tog_pkg::Z_BITS-1:0]         rsp_pos_z,
   input  logic                                      csr_write,
   input  logic [tog_pkg::CSR_INDEX_BITS-1:0]        csr_index,
   input  logic [tog_pkg::CSR_DATA_BITS-1:0]         csr_wdata
);
   import tog_pkg::*;

   localparam int PW   = PERIOD_BITS;
   localparam int FR   = FREQ_BITS - 1;
   localparam int AW   = PW + FR;
   localparam int SZW  = GRID_BITS + 1;
   localparam int NUMW = SZW + PW;
   localparam int QW   = GRID_BITS + ACC_FRAC;
   localparam int SW   = ((QW + 1 > 31) ? QW + 1 : 31) + 2;
   localparam int HW   = SW - ACC_FRAC;
   localparam int ADLY = 1 + QW - TURN_BITS - SINE_LAT;
   localparam int CTW  = FIELD_BITS + ACC_FRAC - 4;
   localparam int ZW   = 2 * FIELD_BITS + 2;
   localparam int T5W  = 1 + POS_FRAC_BITS + Z_BITS;
   localparam int L    = TIME_BITS + FR + QW + HW + 5;

   // configuration
   logic [GRID_REG_BITS-1:0] grid_width_ff, grid_height_ff;
   logic [PW-1:0]            orbit_period_ff;
   logic [AXIS_XY_BITS-1:0]  axis_x_ff, axis_y_ff;
   logic [AXIS_Z_BITS-1:0]   axis_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff   <= GRID_REG_BITS'(1);
         grid_height_ff  <= GRID_REG_BITS'(1);
         orbit_period_ff <= PW'(1);
         axis_x_ff       <= AXIS_XY_RESET;
         axis_y_ff       <= AXIS_XY_RESET;
         axis_z_ff       <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_GRID_WIDTH:   grid_width_ff   <= csr_wdata[GRID_REG_BITS-1:0];
            REG_GRID_HEIGHT:  grid_height_ff  <= csr_wdata[GRID_REG_BITS-1:0];
            REG_ORBIT_PERIOD: orbit_period_ff <= csr_wdata[PW-1:0];
            REG_AXIS_X:       axis_x_ff       <= csr_wdata[AXIS_XY_BITS-1:0];
            REG_AXIS_Y:       axis_y_ff       <= csr_wdata[AXIS_XY_BITS-1:0];
            REG_AXIS_Z:       axis_z_ff       <= csr_wdata[AXIS_Z_BITS-1:0];
            default: ;
         endcase
      end
   end

   logic [PW-1:0]  per;
   logic [SZW-1:0] sz [2];
   logic [GRID_REG_BITS-1:0] grid [2];
   logic signed [FREQ_BITS-1:0]  fmul [4];
   logic [TURN_BITS-1:0]         phase [3];
   logic signed [FIELD_BITS-1:0] amp [3];
   logic signed [FIELD_BITS-1:0] cen [3];

   assign grid[0] = grid_width_ff;
   assign grid[1] = grid_height_ff;
   assign per     = (orbit_period_ff == '0) ? PW'(1) : orbit_period_ff;

   always_comb begin
      for (int j = 0; j < 2; j++) begin
         if (grid[j] == '0) begin
            sz[j] = SZW'(1);
         end else if (32'(grid[j]) > (32'(1) << GRID_BITS)) begin
            sz[j] = SZW'(32'(1) << GRID_BITS);
         end else begin
            sz[j] = SZW'(grid[j]);
         end
      end
   end

   assign fmul[0]  = axis_x_ff[39:32];
   assign fmul[1]  = axis_x_ff[63:56];
   assign fmul[2]  = axis_y_ff[39:32];
   assign fmul[3]  = axis_y_ff[63:56];
   assign phase[0] = axis_x_ff[55:40];
   assign phase[1] = axis_y_ff[55:40];
   assign phase[2] = axis_z_ff[47:32];
   assign amp[0]   = axis_x_ff[31:16];
   assign amp[1]   = axis_y_ff[31:16];
   assign amp[2]   = axis_z_ff[31:16];
   assign cen[0]   = axis_x_ff[15:0];
   assign cen[1]   = axis_y_ff[15:0];
   assign cen[2]   = axis_z_ff[15:0];

   // pipeline control
   logic [L-1:0] v_ff;
   logic         adv;
   logic         rsp_valid_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall || !v_ff[L-1];
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[L-2:0], req_valid};
      end
   end

   // time step mod period
   logic [PW-1:0] r_rem;

   tog_div #(.DW(PW), .NB(TIME_BITS), .TW(1)) u_time_div (
      .clock     (clock),
      .enable    (adv),
      .start_rem ('0),
      .start_num (req_time_step[TIME_BITS-1:0]),
      .divisor   (per),
      .start_tag (1'b0),
      .quotient  (),
      .remainder (r_rem),
      .end_tag   ()
   );

   // frequency and revolution products
   logic signed [FREQ_BITS+PW:0] prod [4];
   logic [AW-1:0] mabs_in [4];
   logic [AW-1:0] mabs_ff [4];
   logic [3:0]    mneg_in, mneg_ff;
   logic [PW-1:0] mr_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         prod[i]    = fmul[i] * $signed({1'b0, r_rem});
         mneg_in[i] = prod[i][FREQ_BITS+PW];
         mabs_in[i] = mneg_in[i] ? AW'(-prod[i]) : AW'(prod[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mabs_ff <= mabs_in;
         mneg_ff <= mneg_in;
         mr_ff   <= r_rem;
      end
   end

   logic [PW-1:0] d2_rem [4];
   logic [PW:0]   d2_tag [4];

   for (genvar i = 0; i < 4; i++) begin : g_fmod
      tog_div #(.DW(PW), .NB(FR), .TW(PW + 1)) u_fmod (
         .clock     (clock),
         .enable    (adv),
         .start_rem (mabs_ff[i][AW-1:FR]),
         .start_num (mabs_ff[i][FR-1:0]),
         .divisor   (per),
         .start_tag ({mneg_ff[i], mr_ff}),
         .quotient  (),
         .remainder (d2_rem[i]),
         .end_tag   (d2_tag[i])
      );
   end

   // positive remainder
   logic [PW-1:0] me_in [4];
   logic [PW-1:0] me_ff [4];
   logic [PW-1:0] re_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         me_in[i] = (d2_tag[i][PW] && d2_rem[i] != '0) ? per - d2_rem[i] : d2_rem[i];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         me_ff <= me_in;
         re_ff <= d2_tag[0][PW-1:0];
      end
   end

   // revolution offset: floor(size * m * 2^18 / period)
   logic [NUMW-1:0] pnum_ff [2];
   logic [QW-1:0]   pq [2];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < 2; j++) begin
            pnum_ff[j] <= NUMW'(sz[j]) * NUMW'(me_ff[2*j+1]);
         end
      end
   end

   for (genvar j = 0; j < 2; j++) begin : g_offs
      tog_div #(.DW(PW), .NB(QW), .TW(1)) u_offs (
         .clock     (clock),
         .enable    (adv),
         .start_rem (pnum_ff[j][GRID_BITS+PW-1:GRID_BITS]),
         .start_num ({pnum_ff[j][GRID_BITS-1:0], {ACC_FRAC{1'b0}}}),
         .divisor   (per),
         .start_tag (1'b0),
         .quotient  (pq[j]),
         .remainder (),
         .end_tag   ()
      );
   end

   // angle and sine, held back to line up with the offset
   logic [3*PW-1:0] adly_ff [ADLY];
   logic [PW-1:0]   am [3];

   always_ff @(posedge clock) begin
      if (adv) begin
         adly_ff[0] <= {me_ff[0], me_ff[2], re_ff};
         for (int k = 1; k < ADLY; k++) begin
            adly_ff[k] <= adly_ff[k-1];
         end
      end
   end

   assign am[0] = adly_ff[ADLY-1][3*PW-1:2*PW];
   assign am[1] = adly_ff[ADLY-1][2*PW-1:PW];
   assign am[2] = adly_ff[ADLY-1][PW-1:0];

   logic [TURN_BITS-1:0] base [3];
   logic [TURN_BITS-1:0] turn [3];
   logic signed [SINE_BITS-1:0] sn [3];

   for (genvar k = 0; k < 3; k++) begin : g_angle
      tog_div #(.DW(PW), .NB(TURN_BITS), .TW(1)) u_angle (
         .clock     (clock),
         .enable    (adv),
         .start_rem (am[k]),
         .start_num ('0),
         .divisor   (per),
         .start_tag (1'b0),
         .quotient  (base[k]),
         .remainder (),
         .end_tag   ()
      );

      assign turn[k] = base[k] + phase[k];

      tog_sine u_sine (
         .clock  (clock),
         .enable (adv),
         .turn   (turn[k]),
         .sine   (sn[k])
      );
   end

   // amplitude products
   logic signed [FIELD_BITS+SINE_BITS-1:0] ap_ff [3];
   logic [QW-1:0] fq_ff [2];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            ap_ff[k] <= amp[k] * sn[k];
         end
         fq_ff <= pq;
      end
   end

   // sum, split into cells and fraction; z rounding and saturation
   logic signed [CTW-1:0] cterm [2];
   logic signed [SW-1:0]  ssum  [2];
   logic signed [SW-1:0]  shi   [2];
   logic [HW-1:0]         habs_in [2];
   logic [HW-1:0]         habs_ff [2];
   logic [1:0]            hneg_in, hneg_ff;
   logic [POS_FRAC_BITS-1:0] hlow_in [2];
   logic [POS_FRAC_BITS-1:0] hlow_ff [2];
   logic signed [ZW-1:0]  zr, zq, zs;
   logic signed [Z_BITS-1:0] z_in, z_ff;

   always_comb begin
      for (int j = 0; j < 2; j++) begin
         cterm[j]   = {cen[j], {(ACC_FRAC-4){1'b0}}};
         ssum[j]    = SW'(cterm[j]) + SW'(ap_ff[j]) + SW'(fq_ff[j]);
         shi[j]     = ssum[j] >>> ACC_FRAC;
         hneg_in[j] = ssum[j][SW-1];
         habs_in[j] = hneg_in[j] ? HW'(-shi[j]) : HW'(shi[j]);
         hlow_in[j] = ssum[j][ACC_FRAC-1 -: POS_FRAC_BITS];
      end
      zr = ZW'(ap_ff[2]) + (ZW'(1) <<< (SIN_ONE_BITS - 1));
      zq = zr >>> SIN_ONE_BITS;
      zs = ZW'(cen[2]) + zq;
      if (zs > ZW'(32767)) begin
         z_in = 16'sh7FFF;
      end else if (zs < -ZW'(32768)) begin
         z_in = 16'sh8000;
      end else begin
         z_in = Z_BITS'(zs);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         habs_ff <= habs_in;
         hneg_ff <= hneg_in;
         hlow_ff <= hlow_in;
         z_ff    <= z_in;
      end
   end

   // wrap cells onto the torus
   logic [SZW-1:0] r5 [2];
   logic [T5W-1:0] t5 [2];

   for (genvar j = 0; j < 2; j++) begin : g_wrap
      tog_div #(.DW(SZW), .NB(HW), .TW(T5W)) u_wrap (
         .clock     (clock),
         .enable    (adv),
         .start_rem ('0),
         .start_num (habs_ff[j]),
         .divisor   (sz[j]),
         .start_tag ({hneg_ff[j], hlow_ff[j], z_ff}),
         .quotient  (),
         .remainder (r5[j]),
         .end_tag   (t5[j])
      );
   end

   logic [SZW-1:0] cell_idx [2];
   logic [GRID_BITS+POS_FRAC_BITS-1:0] pos_in [2];
   logic [GRID_BITS+POS_FRAC_BITS-1:0] rsp_pos_x_ff, rsp_pos_y_ff;
   logic signed [Z_BITS-1:0] rsp_pos_z_ff;

   always_comb begin
      for (int j = 0; j < 2; j++) begin
         cell_idx[j] = (t5[j][T5W-1] && r5[j] != '0) ? sz[j] - r5[j] : r5[j];
         pos_in[j]   = {cell_idx[j][GRID_BITS-1:0], t5[j][Z_BITS +: POS_FRAC_BITS]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || !rsp_stall) begin
         rsp_valid_ff <= v_ff[L-1];
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || !rsp_stall) begin
         rsp_pos_x_ff <= pos_in[0];
         rsp_pos_y_ff <= pos_in[1];
         rsp_pos_z_ff <= t5[0][Z_BITS-1:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pos_x = rsp_pos_x_ff;
   assign rsp_pos_y = rsp_pos_y_ff;
   assign rsp_pos_z = rsp_pos_z_ff;

endmodule

/* tb/tb_toroidal_orbit_generator.sv */
// Self-checking testbench for toroidal_orbit_generator: directed table then random
// time-step requests, results checked against an in-bench fixed-point orbit predictor.
// Depends on tog_pkg and the toroidal_orbit_generator RTL.
module tb_toroidal_orbit_generator;
   import tog_pkg::*;

   localparam int GB = GRID_BITS_DEFAULT;
   localparam int FB = POS_FRAC_BITS_DEFAULT;
   localparam int XYW = GB + FB;
   localparam int LATENCY = 90;
   localparam longint CYCLE_LIMIT = 3_000_000;

   typedef struct {
      logic [XYW-1:0] x;
      logic [XYW-1:0] y;
      logic [15:0]    z;
   } point_type;

   typedef struct {
      logic [31:0] t;
      bit          known;
      point_type   pt;
   } row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [31:0] req_time_step = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [XYW-1:0] rsp_pos_x, rsp_pos_y;
   logic signed [15:0] rsp_pos_z;
   logic csr_write = 0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [63:0] csr_wdata = '0;

   toroidal_orbit_generator u_top (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   logic [12:0] width_reg, height_reg;
   logic [15:0] period_reg;
   logic [63:0] axis_x_reg, axis_y_reg;
   logic [47:0] axis_z_reg;

   point_type points_due[$];
   int errors = 0;
   longint cycles = 0;
   bit rsp_hold_on = 0;

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
      errors++;
   endtask

   function automatic longint pmod(longint v, longint m);
      longint r = v % m;
      return r < 0 ? r + m : r;
   endfunction

   function automatic longint sine_of(logic [15:0] turn);
      longint u, x2, t, s;
      u = turn[13:0];
      if (turn[14]) u = 16384 - u;
      x2 = (u * u) >>> 14;
      t = 10512 - ((x2 * 1160) >>> 14);
      t = 25736 - ((x2 * t) >>> 14);
      s = (u * t) >>> 14;
      return turn[15] ? -s : s;
   endfunction

   function automatic logic [15:0] turn_of(longint f, longint r, longint p, logic [15:0] ph);
      longint m = pmod(f * r, p);
      return 16'((m * 65536) / p + ph);
   endfunction

   function automatic longint grid_of(logic [12:0] g);
      if (g == 0) return 1;
      return g > (1 << GB) ? (1 << GB) : g;
   endfunction

   function automatic logic [XYW-1:0] axis_of(logic [63:0] su, longint sz, longint r, longint p);
      longint c, a, f, rv, s;
      c = longint'(signed'(su[15:0]));
      a = longint'(signed'(su[31:16]));
      f = longint'(signed'(su[39:32]));
      rv = longint'(signed'(su[63:56]));
      s = c * (1 << 14) + a * sine_of(turn_of(f, r, p, su[55:40]));
      s += (sz * pmod(rv * r, p) * (1 << 18)) / p;
      s = pmod(s, sz * (1 << 18));
      return XYW'(s >> (18 - FB));
   endfunction

   function automatic point_type orbit_point(logic [31:0] t);
      point_type pt;
      longint p, r, cz, az, prod, q, z;
      p = period_reg == 0 ? 1 : period_reg;
      r = longint'({32'd0, t}) % p;
      pt.x = axis_of(axis_x_reg, grid_of(width_reg), r, p);
      pt.y = axis_of(axis_y_reg, grid_of(height_reg), r, p);
      cz = longint'(signed'(axis_z_reg[15:0]));
      az = longint'(signed'(axis_z_reg[31:16]));
      prod = az * sine_of(turn_of(1, r, p, axis_z_reg[47:32])) + 8192;
      q = prod / 16384;
      if (prod % 16384 != 0 && prod < 0) q--;
      z = cz + q;
      if (z > 32767) z = 32767;
      if (z < -32768) z = -32768;
      pt.z = 16'(z);
      return pt;
   endfunction

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (points_due.size() == 0) begin
            report("unexpected point", rsp_pos_x, 0);
         end else begin
            point_type w;
            w = points_due.pop_front();
            if (rsp_pos_x !== w.x) report("pos_x", rsp_pos_x, w.x);
            if (rsp_pos_y !== w.y) report("pos_y", rsp_pos_y, w.y);
            if (rsp_pos_z !== w.z) report("pos_z", rsp_pos_z, w.z);
         end
      end
   end

   // receiver stall pattern: random waits per point, or none
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (rsp_hold_on) begin
            n = $urandom_range(0, 18);
            rsp_stall <= n != 0;
            repeat (n) @(negedge clock);
            rsp_stall <= 0;
            @(posedge clock);
            while (!rsp_valid) @(posedge clock);
         end else begin
            rsp_stall <= 0;
         end
      end
   end

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx, input logic [63:0] v);
      @(negedge clock);
      csr_write <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      @(negedge clock);
      csr_write <= 0;
      case (idx)
         REG_GRID_WIDTH:   width_reg = v[12:0];
         REG_GRID_HEIGHT:  height_reg = v[12:0];
         REG_ORBIT_PERIOD: period_reg = v[15:0];
         REG_AXIS_X:       axis_x_reg = v;
         REG_AXIS_Y:       axis_y_reg = v;
         REG_AXIS_Z:       axis_z_reg = v[47:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      while (points_due.size() != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
   endtask

   // send one request; gap drawn per request, valid held across back-to-back requests
   task automatic send(input logic [31:0] t, input bit gaps);
      int n = gaps ? $urandom_range(0, 18) : 0;
      if (n != 0) begin
         req_valid <= 0;
         repeat (n) @(negedge clock);
      end
      req_valid <= 1;
      req_time_step <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      points_due.push_back(orbit_point(t));
      @(negedge clock);
   endtask

   task automatic idle_req();
      req_valid <= 0;
      @(negedge clock);
   endtask

   function automatic logic [31:0] rand_time();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 300);
         1: return 32'hFFFF_FFFF - $urandom_range(0, 50);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [63:0] rand_axis();
      logic [63:0] v = {$urandom, $urandom};
      if ($urandom_range(0, 2) == 0) v[31:16] = 16'($signed(15'($urandom)) >>> 3);
      return v;
   endfunction

   row_type directed[$];

   initial begin
      point_type zero_pt;
      logic [12:0] grids[$];
      logic [15:0] periods[$];
      width_reg = 1; height_reg = 1; period_reg = 1;
      axis_x_reg = AXIS_XY_RESET; axis_y_reg = AXIS_XY_RESET; axis_z_reg = '0;
      zero_pt.x = '0; zero_pt.y = '0; zero_pt.z = '0;
      repeat (11) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // after reset every point is the origin
      foreach (directed[i]) ;
      directed.push_back('{32'd0, 1, zero_pt});
      directed.push_back('{32'd1, 1, zero_pt});
      directed.push_back('{32'hFFFF_FFFF, 1, zero_pt});
      directed.push_back('{32'h8000_0000, 1, zero_pt});
      foreach (directed[i]) begin
         send(directed[i].t, 0);
         if (directed[i].known) points_due[$] = directed[i].pt;
      end
      idle_req();
      drain();

      // extremes: full grid, largest amplitudes, period zero and max
      write_reg(REG_GRID_WIDTH, 64'h1FFF);
      write_reg(REG_GRID_HEIGHT, 64'hFFFF_0000);
      write_reg(REG_ORBIT_PERIOD, 64'hFFFF);
      write_reg(REG_AXIS_X, 64'h7F12_3480_7FFF_8000);
      write_reg(REG_AXIS_Y, 64'h80FF_FF7F_8000_7FFF);
      write_reg(REG_AXIS_Z, 64'hFFFF_4000_7FFF_7FFF);
      write_reg(3'd6, 64'hDEAD);
      write_reg(3'd7, 64'hBEEF);
      directed.delete();
      foreach (periods[i]) ;
      for (int i = 0; i < 8; i++) send(i * 8191, 0);
      send(32'hFFFF_FFFF, 0);
      send(32'd65534, 0);
      idle_req();
      drain();
      write_reg(REG_ORBIT_PERIOD, 64'h0);
      write_reg(REG_GRID_WIDTH, 64'h0);
      write_reg(REG_AXIS_Z, 64'h0000_8000_8000);
      send(32'd12345, 0);
      send(32'hFFFF_FFFF, 0);
      idle_req();
      drain();
      write_reg(REG_AXIS_Z, 64'h0000_7FFF_8001);
      send(32'd3, 0);
      idle_req();
      drain();
      write_reg(REG_AXIS_Z, 64'h4000_8000_7FFF);
      send(32'd77, 0);
      idle_req();
      drain();

      grids = '{13'd1, 13'd4096, 13'd4097, 13'd7, 13'd640};
      periods = '{16'd1, 16'd0, 16'd65535, 16'd3, 16'd1000};
      rsp_hold_on = 1;
      for (int ph = 0; ph < 12; ph++) begin
         int k;
         k = ph < grids.size() ? ph : $urandom_range(0, grids.size() - 1);
         write_reg(REG_GRID_WIDTH, ph < 5 ? grids[k] : $urandom_range(1, 4096));
         write_reg(REG_GRID_HEIGHT, ph < 5 ? grids[4 - k] : $urandom);
         write_reg(REG_ORBIT_PERIOD, ph < 5 ? periods[k] : $urandom_range(0, 2000));
         write_reg(REG_AXIS_X, rand_axis());
         write_reg(REG_AXIS_Y, rand_axis());
         write_reg(REG_AXIS_Z, {$urandom, $urandom});
         for (int i = 0; i < 130; i++) begin
            send(rand_time(), ($urandom_range(0, 3) != 0) && (ph % 4 != 3));
            if (i == 60 && ph == 2) begin
               idle_req();
               while (points_due.size() != 0) @(negedge clock);
            end
         end
         idle_req();
         drain();
      end
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/core/tog_pkg.sv
rtl/core/tog_div.sv
rtl/core/tog_sine.sv
rtl/core/toroidal_orbit_generator.sv
tb/tb_toroidal_orbit_generator.sv
